// ----- hw/rtl/cfd_pkg.sv -----
// Package with shared constants, types and helpers for the complex FIR decimator.
`timescale 1ns / 1ps
package cfd_pkg;
    localparam int MAX_TAPS    = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int ADDR_BITS   = $clog2(MAX_TAPS);
    localparam int TAPC_BITS   = 11;
    localparam int DEC_BITS    = 7;
    localparam int CFG_BITS    = 11;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + ADDR_BITS + 1;

    localparam logic [1:0] CFG_TAP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DECIMATION = 2'd1;
    localparam logic [1:0] CFG_BYPASS     = 2'd2;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_LOAD    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_BYPASS = 2'd0,
        OP_FILTER = 2'd1
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic [ADDR_BITS-1:0]          base;
        logic [ADDR_BITS:0]            taps;
        logic signed [SAMPLE_BITS-1:0] si;
        logic signed [SAMPLE_BITS-1:0] sq;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    function automatic logic [SAMPLE_BITS:0] scale_sat(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] x;
        logic signed [ACC_BITS-1:0] r;
        logic [SAMPLE_BITS:0] res;
        x = acc + (ACC_BITS'(1) <<< (COEF_BITS - 2));
        r = x >>> (COEF_BITS - 1);
        if (r > ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1))
            res = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (r < -ACC_BITS'(1 << (SAMPLE_BITS - 1)))
            res = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            res = {1'b0, r[SAMPLE_BITS-1:0]};
        return res;
    endfunction
endpackage

// ----- hw/rtl/complex_fir_decimator.sv -----
// Top level of the complex FIR decimator with its configuration registers.
// Usage: the input channel (in_valid/in_stall) carries requests: samples,
// coefficient loads and stream restarts. The output channel (out_valid/out_stall)
// carries filtered or bypassed samples with a saturation flag.
// The user must make configuration writes (cfg_we, cfg_index, cfg_data) while idle;
// the block does not enforce it. Loads and restarts finish in the cycle they
// transfer and give no output. A bypass result passes through the queue and then
// the output register, and the input stalls while that command waits in the queue.
// A filtered output passes through the queue, the memory read registers, the
// product registers, the accumulators and the output register; the single shared
// complex multiply-accumulate reads one tap and one history entry per cycle from
// the memories, and the next input transfer waits until the back part is idle.
// A two-entry command queue sits between the front and back parts; the input
// stalls while the queue holds a command or the back part is busy, so samples
// and loads never change the memories under a running sum.
// When the receiver stalls, the output register holds its result and the
// back part waits, which in turn stalls the input.
// Reset clears the pointers, sets the phase counter to 30 and sets the registers to
// tap_count 31, decimation 1 and bypass on; the memories are not cleared.
`timescale 1ns / 1ps
module complex_fir_decimator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [cfd_pkg::ADDR_BITS-1:0]     coef_index,
    input  logic signed [cfd_pkg::COEF_BITS-1:0]   coef_value,
    input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] sample_i,
    input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] sample_q,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cfd_pkg::SAMPLE_BITS-1:0] out_i,
    output logic signed [cfd_pkg::SAMPLE_BITS-1:0] out_q,
    output logic                              saturated,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [cfd_pkg::CFG_BITS-1:0]      cfg_data
);
    import cfd_pkg::*;

    logic [TAPC_BITS-1:0] tap_count_reg;
    logic [DEC_BITS-1:0]  decimation_reg;
    logic                 bypass_reg;
    logic                 q_full, q_empty, q_push, q_pop;
    logic                 back_busy;
    cmd_t                 q_cmd, q_head;
    logic                 coef_we, hist_we;
    logic [ADDR_BITS-1:0] coef_waddr, hist_waddr;
    logic [COEF_BITS-1:0] coef_wdata;
    logic [2*SAMPLE_BITS-1:0] hist_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg  <= TAPC_BITS'(31);
            decimation_reg <= DEC_BITS'(1);
            bypass_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_COUNT:  tap_count_reg  <= cfg_data[TAPC_BITS-1:0];
                CFG_DECIMATION: decimation_reg <= cfg_data[DEC_BITS-1:0];
                CFG_BYPASS:     bypass_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cfd_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .req_type, .coef_index, .coef_value,
        .sample_i, .sample_q,
        .tap_count(tap_count_reg), .decimation(decimation_reg), .bypass(bypass_reg),
        .q_full, .q_empty, .back_busy, .q_push, .q_cmd, .coef_we, .coef_waddr,
        .coef_wdata, .hist_we, .hist_waddr, .hist_wdata
    );

    cfd_queue u_queue (
        .clk, .rst_n, .push(q_push), .push_cmd(q_cmd), .full(q_full),
        .pop(q_pop), .empty(q_empty), .head(q_head)
    );

    cfd_back u_back (
        .clk, .rst_n, .coef_we, .coef_waddr, .coef_wdata, .hist_we, .hist_waddr,
        .hist_wdata, .q_empty, .q_head, .q_pop, .busy(back_busy), .out_valid,
        .out_stall, .out_i, .out_q, .saturated
    );
endmodule

// ----- hw/rtl/cfd_front.sv -----
// Front part: request decode, coefficient and history writes, output phase tracking.
`timescale 1ns / 1ps
module cfd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [cfd_pkg::ADDR_BITS-1:0]     coef_index,
    input  logic signed [cfd_pkg::COEF_BITS-1:0]   coef_value,
    input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] sample_i,
    input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] sample_q,
    input  logic [cfd_pkg::TAPC_BITS-1:0]     tap_count,
    input  logic [cfd_pkg::DEC_BITS-1:0]      decimation,
    input  logic                              bypass,
    input  logic                              q_full,
    input  logic                              q_empty,
    input  logic                              back_busy,
    output logic                              q_push,
    output cfd_pkg::cmd_t                     q_cmd,
    output logic                              coef_we,
    output logic [cfd_pkg::ADDR_BITS-1:0]     coef_waddr,
    output logic [cfd_pkg::COEF_BITS-1:0]     coef_wdata,
    output logic                              hist_we,
    output logic [cfd_pkg::ADDR_BITS-1:0]     hist_waddr,
    output logic [2*cfd_pkg::SAMPLE_BITS-1:0] hist_wdata
);
    import cfd_pkg::*;

    logic [ADDR_BITS-1:0] wp_reg, wp_next;
    logic [ADDR_BITS-1:0] wait_reg, wait_next;
    logic [ADDR_BITS:0]   eff_taps;
    logic [DEC_BITS-1:0]  eff_dec;
    logic                 acc;
    req_t                 req;

    // The memories must not change while the back part still reads them.
    assign req      = req_t'(req_type);
    assign in_stall = q_full || !q_empty || back_busy;
    assign acc      = in_valid && !in_stall;
    assign eff_taps = (tap_count == '0) ? (ADDR_BITS+1)'(1) :
                      (tap_count > TAPC_BITS'(MAX_TAPS)) ? (ADDR_BITS+1)'(MAX_TAPS) :
                      tap_count[ADDR_BITS:0];
    assign eff_dec  = (decimation == '0) ? DEC_BITS'(1) : decimation;

    assign coef_we    = acc && req == REQ_LOAD;
    assign coef_waddr = coef_index;
    assign coef_wdata = coef_value;
    assign hist_we    = acc && req == REQ_SAMPLE && !bypass;
    assign hist_waddr = wp_reg;
    assign hist_wdata = {sample_q, sample_i};

    always_comb
    begin
        wp_next     = wp_reg;
        wait_next   = wait_reg;
        q_push      = 1'b0;
        q_cmd.op    = bypass ? OP_BYPASS : OP_FILTER;
        q_cmd.base  = wp_reg;
        q_cmd.taps  = eff_taps;
        q_cmd.si    = sample_i;
        q_cmd.sq    = sample_q;
        if (acc)
        begin
            case (req)
                REQ_RESTART:
                begin
                    wp_next   = '0;
                    wait_next = ADDR_BITS'(eff_taps - 1'b1);
                end
                REQ_SAMPLE:
                begin
                    if (bypass)
                        q_push = 1'b1;
                    else
                    begin
                        wp_next = wp_reg + 1'b1;
                        if (wait_reg != '0)
                            wait_next = wait_reg - 1'b1;
                        else
                        begin
                            wait_next = ADDR_BITS'(eff_dec - 1'b1);
                            q_push    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            wait_reg <= ADDR_BITS'(30);
        end
        else
        begin
            wp_reg   <= wp_next;
            wait_reg <= wait_next;
        end
    end
endmodule

// ----- hw/rtl/cfd_queue.sv -----
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
module cfd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output cfd_pkg::cmd_t head
);
    import cfd_pkg::*;

    cmd_t       mem_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- hw/rtl/cfd_back.sv -----
// Back part: tap and history memories with one shared complex multiply-accumulate.
`timescale 1ns / 1ps
module cfd_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              coef_we,
    input  logic [cfd_pkg::ADDR_BITS-1:0]     coef_waddr,
    input  logic [cfd_pkg::COEF_BITS-1:0]     coef_wdata,
    input  logic                              hist_we,
    input  logic [cfd_pkg::ADDR_BITS-1:0]     hist_waddr,
    input  logic [2*cfd_pkg::SAMPLE_BITS-1:0] hist_wdata,
    input  logic                              q_empty,
    input  cfd_pkg::cmd_t                     q_head,
    output logic                              q_pop,
    output logic                              busy,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cfd_pkg::SAMPLE_BITS-1:0] out_i,
    output logic signed [cfd_pkg::SAMPLE_BITS-1:0] out_q,
    output logic                              saturated
);
    import cfd_pkg::*;

    logic [COEF_BITS-1:0]     coef_mem [MAX_TAPS];
    logic [2*SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

    state_t state_reg, state_next;
    logic [ADDR_BITS:0]   j_reg, j_next;
    logic [ADDR_BITS:0]   taps_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] haddr;
    logic [COEF_BITS-1:0] c_rd_reg;
    logic [2*SAMPLE_BITS-1:0] h_rd_reg;
    logic                 rd_v_reg, rd_en;
    logic signed [PROD_BITS-1:0] pi_reg, pq_reg;
    logic                 p_v_reg;
    logic signed [ACC_BITS-1:0]  acc_i_reg, acc_q_reg;
    logic [SAMPLE_BITS:0] si_sat, sq_sat;
    logic                 out_free;
    logic                 out_load_bp, out_load_f;

    assign busy     = state_reg != ST_IDLE;
    assign out_free = !out_valid || !out_stall;
    assign haddr    = ADDR_BITS'(base_reg - taps_reg[ADDR_BITS-1:0] + 1'b1 + j_reg[ADDR_BITS-1:0]);
    assign si_sat   = scale_sat(acc_i_reg);
    assign sq_sat   = scale_sat(acc_q_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!q_empty && q_head.op == OP_FILTER)
                    state_next = ST_RUN;
            ST_RUN:
                if (j_reg == taps_reg - 1'b1)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!rd_v_reg && !p_v_reg)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        out_load_bp = 1'b0;
        out_load_f  = 1'b0;
        j_next      = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                j_next = '0;
                if (!q_empty && q_head.op == OP_BYPASS && out_free)
                begin
                    q_pop       = 1'b1;
                    out_load_bp = 1'b1;
                end
                else if (!q_empty && q_head.op == OP_FILTER)
                    q_pop = 1'b1;
            end
            ST_RUN:
            begin
                rd_en  = 1'b1;
                j_next = j_reg + 1'b1;
            end
            ST_OUT:
                out_load_f = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_wdata;
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        c_rd_reg <= coef_mem[j_reg[ADDR_BITS-1:0]];
        h_rd_reg <= hist_mem[haddr];
        pi_reg   <= $signed(c_rd_reg) * $signed(h_rd_reg[SAMPLE_BITS-1:0]);
        pq_reg   <= $signed(c_rd_reg) * $signed(h_rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        if (state_reg == ST_IDLE)
        begin
            taps_reg <= q_head.taps;
            base_reg <= q_head.base;
        end
        if (state_reg == ST_IDLE)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (p_v_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_BITS'(pi_reg);
            acc_q_reg <= acc_q_reg + ACC_BITS'(pq_reg);
        end
        if (out_load_bp)
        begin
            out_i     <= q_head.si;
            out_q     <= q_head.sq;
            saturated <= 1'b0;
        end
        else if (out_load_f)
        begin
            out_i     <= si_sat[SAMPLE_BITS-1:0];
            out_q     <= sq_sat[SAMPLE_BITS-1:0];
            saturated <= si_sat[SAMPLE_BITS] | sq_sat[SAMPLE_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            rd_v_reg  <= 1'b0;
            p_v_reg   <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            rd_v_reg  <= rd_en;
            p_v_reg   <= rd_v_reg;
            if (out_load_bp || out_load_f)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end
endmodule

// ----- hw/rtl/cfd_checker.sv -----
// Port-level checker for the complex FIR decimator and its bind statement.
`timescale 1ns / 1ps
module cfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] out_i,
    input logic        saturated
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_i))
        else $error("output changed while stalled");
    a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && !in_stall && req_type != 2'd0 |=> !out_valid)
        else $error("output appeared after a request without result");
    a_sat_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(saturated))
        else $error("saturation flag unknown");
endmodule

bind complex_fir_decimator cfd_checker u_cfd_checker (
    .clk, .rst_n, .in_valid, .in_stall, .req_type, .out_valid, .out_stall,
    .out_i, .saturated
);
